// File: design/qaos_pkg.sv
package qaos_pkg;

	localparam int CAP_W      = 13;
	localparam int POS_W      = 12;
	localparam int FIFO_DEPTH = 4;

	localparam logic [7:0] CH_SEMI = 8'h3B;
	localparam logic [7:0] CH_AMP  = 8'h26;
	localparam logic [7:0] CH_BAR  = 8'h7C;
	localparam logic [7:0] CH_GT   = 8'h3E;
	localparam logic [7:0] CH_SQ   = 8'h27;
	localparam logic [7:0] CH_DQ   = 8'h22;
	localparam logic [7:0] CH_BSL  = 8'h5C;
	localparam logic [7:0] CH_SP   = 8'h20;
	localparam logic [7:0] CH_TAB  = 8'h09;
	localparam logic [7:0] CH_CR   = 8'h0D;
	localparam logic [7:0] CH_LF   = 8'h0A;

	localparam logic [1:0] KIND_SEMI = 2'd0;
	localparam logic [1:0] KIND_AND  = 2'd1;
	localparam logic [1:0] KIND_OR   = 2'd2;
	localparam logic [1:0] KIND_BG   = 2'd3;

	localparam logic [1:0] ST_NONE  = 2'd0;
	localparam logic [1:0] ST_SPLIT = 2'd1;
	localparam logic [1:0] ST_ERR   = 2'd2;

	localparam logic [7:0] REG_KIND = 8'd0;
	localparam logic [7:0] REG_LCAP = 8'd1;
	localparam logic [7:0] REG_RCAP = 8'd2;

	localparam logic [CAP_W-1:0] CAP_RESET = 13'd256;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       end_of_line;
	} cmd_t;

	typedef struct packed {
		logic [7:0]       out_byte;
		logic             side;
		logic [POS_W-1:0] position;
		logic             is_final;
		logic [1:0]       status;
		logic [POS_W-1:0] left_length;
		logic [POS_W-1:0] right_length;
	} res_t;

	typedef struct packed {
		logic [7:0]       index;
		logic [CAP_W-1:0] value;
	} cfg_wr_t;

	typedef struct packed {
		logic [1:0]       split_kind;
		logic [CAP_W-1:0] left_capacity;
		logic [CAP_W-1:0] right_capacity;
	} cfg_t;

	typedef struct packed {
		logic byte_v;
		logic fin_v;
		res_t byte_res;
		res_t fin_res;
	} push_t;

	function automatic logic is_ws(input logic [7:0] c);
		return c == CH_SP || c == CH_TAB || c == CH_CR || c == CH_LF;
	endfunction

endpackage

// File: design/qaos_stream_if.sv
interface qaos_stream_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// File: design/qaos_core.sv
module qaos_core #(
	parameter int MAX_LENGTH = 4096
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            adv,
	input  qaos_pkg::cmd_t  item,
	input  qaos_pkg::cfg_t  cfg,
	output qaos_pkg::push_t push
);
	import qaos_pkg::*;

	localparam int CW = $clog2(MAX_LENGTH + 1);
	localparam int EW = ((CW > CAP_W) ? CW : CAP_W) + 1;

	localparam logic [1:0] DELIM_NONE = 2'd0;
	localparam logic [1:0] DELIM_ONE  = 2'd1;
	localparam logic [1:0] DELIM_TWO  = 2'd2;

	localparam logic [1:0] NEED_NONE = 2'd0;
	localparam logic [1:0] NEED_ONE  = 2'd1;
	localparam logic [1:0] NEED_TWO  = 2'd2;

	logic [7:0]    pc_q, bc_q, ln_q;
	logic          pv_q, esc_q, skip_q, sq_q, dq_q, op_q, err_q;
	logic [CW-1:0] raw_q  [2];
	logic [CW-1:0] kept_q [2];
	logic [CW-1:0] trim_q [2];

	logic [7:0]    n_pc, n_bc, n_ln;
	logic          n_pv, n_esc, n_skip, n_sq, n_dq, n_op, n_err;
	logic [CW-1:0] n_raw  [2];
	logic [CW-1:0] n_kept [2];
	logic [CW-1:0] n_trim [2];

	logic [7:0]    c, nx;
	logic          nv, s, keep_req, nesc, nskip;
	logic [1:0]    need, delim, status;
	logic [EW-1:0] lcap_e, rcap_e, cap_s;
	res_t          byte_res, fin_res;
	logic          byte_v, fin_v;

	// clamp capacities to the buffer limit
	always_comb begin
		lcap_e = (EW'(cfg.left_capacity) > EW'(MAX_LENGTH)) ? EW'(MAX_LENGTH)
			: EW'(cfg.left_capacity);
		rcap_e = (EW'(cfg.right_capacity) > EW'(MAX_LENGTH)) ? EW'(MAX_LENGTH)
			: EW'(cfg.right_capacity);
	end

	always_comb begin
		n_pc = pc_q; n_bc = bc_q; n_ln = ln_q;
		n_pv = pv_q; n_esc = esc_q; n_skip = skip_q;
		n_sq = sq_q; n_dq = dq_q; n_op = op_q; n_err = err_q;
		n_raw = raw_q; n_kept = kept_q; n_trim = trim_q;

		nv = !item.end_of_line;
		nx = item.end_of_line ? 8'd0 : item.in_byte;
		c = pc_q;
		s = op_q;
		cap_s = s ? rcap_e : lcap_e;
		keep_req = 1'b0; need = NEED_NONE; nesc = 1'b0; nskip = 1'b0;
		delim = DELIM_NONE; status = ST_NONE;
		byte_v = 1'b0; byte_res = '0;
		fin_v = 1'b0; fin_res = '0;

		if (adv && pv_q) begin
			if (skip_q) begin
				// second byte of a two-byte operator: drop
			end else if (esc_q) begin
				keep_req = !err_q;
			end else if (!sq_q && c == CH_BSL && nv) begin
				keep_req = !err_q;
				need = NEED_TWO;
				nesc = 1'b1;
			end else begin
				if (!dq_q && c == CH_SQ) begin
					n_sq = !sq_q;
				end else if (!sq_q && c == CH_DQ) begin
					n_dq = !dq_q;
				end
				if (!op_q && !n_sq && !n_dq) begin
					case (cfg.split_kind)
						KIND_SEMI: begin
							if (c == CH_SEMI) delim = DELIM_ONE;
						end
						KIND_AND: begin
							if (c == CH_AMP && nv && nx == CH_AMP) delim = DELIM_TWO;
						end
						KIND_OR: begin
							if (c == CH_BAR && nv && nx == CH_BAR) delim = DELIM_TWO;
						end
						default: begin
							// lone ampersand, not a redirect target
							if (c == CH_AMP && !(nv && nx == CH_AMP) && bc_q != CH_AMP
								&& ln_q != CH_GT) delim = DELIM_ONE;
						end
					endcase
				end
				if (delim != DELIM_NONE) begin
					n_op = 1'b1;
					nskip = (delim == DELIM_TWO);
				end else begin
					keep_req = !err_q;
					need = NEED_ONE;
				end
			end

			if (keep_req) begin
				if (need != NEED_NONE && (EW'(raw_q[s]) + EW'(need) >= cap_s)) begin
					n_err = 1'b1;
				end else begin
					n_raw[s] = CW'(raw_q[s] + 1'b1);
					if (!(kept_q[s] == '0 && is_ws(c))) begin
						byte_v = 1'b1;
						byte_res.out_byte = c;
						byte_res.side = s;
						byte_res.position = POS_W'(kept_q[s]);
						n_kept[s] = CW'(kept_q[s] + 1'b1);
						if (!is_ws(c)) n_trim[s] = CW'(kept_q[s] + 1'b1);
					end
				end
			end

			n_bc = c;
			if (!is_ws(c)) n_ln = c;
			n_pc = nx;
			n_pv = nv;
			n_esc = nesc;
			n_skip = nskip;
		end else if (adv && !item.end_of_line) begin
			n_pc = item.in_byte;
			n_pv = 1'b1;
			n_esc = 1'b0;
			n_skip = 1'b0;
		end

		if (adv && item.end_of_line) begin
			if (n_err || cfg.left_capacity == '0 || cfg.right_capacity == '0) begin
				status = ST_ERR;
			end else if (cfg.split_kind == KIND_BG && (n_sq || n_dq)) begin
				status = ST_ERR;
			end else if (!n_op) begin
				status = ST_NONE;
			end else if (n_trim[0] == '0) begin
				status = ST_ERR;
			end else if (cfg.split_kind == KIND_BG) begin
				status = (n_trim[1] == '0) ? ST_NONE : ST_SPLIT;
			end else begin
				status = (n_trim[1] == '0) ? ST_ERR : ST_SPLIT;
			end
			fin_v = 1'b1;
			fin_res.is_final = 1'b1;
			fin_res.status = status;
			if (status != ST_ERR) begin
				fin_res.left_length = POS_W'(n_trim[0]);
				fin_res.right_length = n_op ? POS_W'(n_trim[1]) : '0;
			end
			// start the next line from a clean state
			n_pc = '0; n_bc = '0; n_ln = '0;
			n_pv = 1'b0; n_esc = 1'b0; n_skip = 1'b0;
			n_sq = 1'b0; n_dq = 1'b0; n_op = 1'b0; n_err = 1'b0;
			n_raw[0] = '0; n_raw[1] = '0;
			n_kept[0] = '0; n_kept[1] = '0;
			n_trim[0] = '0; n_trim[1] = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= '0; bc_q <= '0; ln_q <= '0;
			pv_q <= 1'b0; esc_q <= 1'b0; skip_q <= 1'b0;
			sq_q <= 1'b0; dq_q <= 1'b0; op_q <= 1'b0; err_q <= 1'b0;
			raw_q[0] <= '0; raw_q[1] <= '0;
			kept_q[0] <= '0; kept_q[1] <= '0;
			trim_q[0] <= '0; trim_q[1] <= '0;
		end else begin
			pc_q <= n_pc; bc_q <= n_bc; ln_q <= n_ln;
			pv_q <= n_pv; esc_q <= n_esc; skip_q <= n_skip;
			sq_q <= n_sq; dq_q <= n_dq; op_q <= n_op; err_q <= n_err;
			raw_q <= n_raw;
			kept_q <= n_kept;
			trim_q <= n_trim;
		end
	end

	assign push.byte_v = byte_v;
	assign push.fin_v = fin_v;
	assign push.byte_res = byte_res;
	assign push.fin_res = fin_res;

	a_final_on_eol: assert property (@(posedge clk) disable iff (!arst_n)
		adv && item.end_of_line |-> push.fin_v)
		else $error("end of line without closing item");

	a_byte_needs_pending: assert property (@(posedge clk) disable iff (!arst_n)
		push.byte_v |-> pv_q && !skip_q)
		else $error("byte emitted without a held byte");

	a_clear_after_eol: assert property (@(posedge clk) disable iff (!arst_n)
		adv && item.end_of_line |=> !pv_q && !op_q && !err_q && !sq_q && !dq_q)
		else $error("line state not cleared");

endmodule

// File: design/qaos_fifo.sv
module qaos_fifo (
	input  logic                  clk,
	input  logic                  arst_n,
	input  qaos_pkg::push_t       push,
	qaos_stream_if.source         res,
	output logic                  room2
);
	import qaos_pkg::*;

	localparam int PW = $clog2(FIFO_DEPTH);
	localparam int NW = $clog2(FIFO_DEPTH + 1);

	res_t          mem_q [FIFO_DEPTH];
	logic [PW-1:0] wr_q, rd_q;
	logic [NW-1:0] cnt_q, n_push;
	logic          pop;

	assign res.valid = (cnt_q != '0);
	assign res.data = mem_q[rd_q];
	assign pop = res.valid && res.ready;
	assign n_push = NW'(push.byte_v) + NW'(push.fin_v);
	assign room2 = (cnt_q - NW'(pop)) <= NW'(FIFO_DEPTH - 2);

	// byte item goes ahead of the closing item
	always_ff @(posedge clk) begin
		if (push.byte_v) begin
			mem_q[wr_q] <= push.byte_res;
			if (push.fin_v) mem_q[PW'(wr_q + 1'b1)] <= push.fin_res;
		end else if (push.fin_v) begin
			mem_q[wr_q] <= push.fin_res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			wr_q <= PW'(wr_q + n_push);
			if (pop) rd_q <= PW'(rd_q + 1'b1);
			cnt_q <= NW'(cnt_q + n_push - NW'(pop));
		end
	end

	a_push_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		(push.byte_v || push.fin_v) |-> room2)
		else $error("push into a full result queue");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= NW'(FIFO_DEPTH))
		else $error("result queue count out of range");

endmodule

// File: design/quote_aware_operator_splitter_unit.sv
// An item is registered at accept and processed once the result queue has room for two;
// its results are written into that queue. A byte comes out once the following item (next
// byte or end of line) is processed, since one byte is held for lookahead.
// Throughput: one item per cycle; end of line pushes up to two items into a four-entry
// result queue, and input ready drops only while that queue lacks room for two.
// Reset (arst_n low) clears the line state, the queue and the registers to their defaults.
module quote_aware_operator_splitter_unit #(
	parameter int MAX_LENGTH = 4096
) (
	input  logic          clk,
	input  logic          arst_n,
	qaos_stream_if.sink   cmd,
	qaos_stream_if.source res,
	qaos_stream_if.sink   cfg
);
	import qaos_pkg::*;

	cfg_t  cfg_q;
	cmd_t  item_s1;
	logic  v_s1;
	logic  room2, adv;
	push_t push;

	assign adv = v_s1 && room2;
	assign cmd.ready = !v_s1 || room2;
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.split_kind <= KIND_SEMI;
			cfg_q.left_capacity <= CAP_RESET;
			cfg_q.right_capacity <= CAP_RESET;
		end else if (cfg.valid) begin
			case (cfg.data.index)
				REG_KIND: cfg_q.split_kind <= cfg.data.value[1:0];
				REG_LCAP: cfg_q.left_capacity <= cfg.data.value;
				REG_RCAP: cfg_q.right_capacity <= cfg.data.value;
				default: begin
					// unknown register: drop
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (cmd.valid && cmd.ready) begin
			v_s1 <= 1'b1;
		end else if (adv) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) item_s1 <= cmd.data;
	end

	qaos_core #(.MAX_LENGTH(MAX_LENGTH)) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.item   (item_s1),
		.cfg    (cfg_q),
		.push   (push)
	);

	qaos_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.res    (res),
		.room2  (room2)
	);

endmodule

// File: test/qaos_checker.sv
module qaos_checker (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	input  logic              cmd_ready,
	input  qaos_pkg::cmd_t    cmd_data,
	input  logic              res_valid,
	input  logic              res_ready,
	input  qaos_pkg::res_t    res_data,
	input  logic              cfg_valid,
	input  logic              cfg_ready,
	input  qaos_pkg::cfg_wr_t cfg_data,
	output int                mismatches,
	output int                outstanding,
	output int                lines_seen,
	output int                results_checked
);
	timeunit 1ns;
	timeprecision 1ps;
	import qaos_pkg::*;

	localparam int LINE_LIMIT = 4096;

	logic [1:0] kind;
	int         left_cap;
	int         right_cap;

	logic [7:0] held_ch;
	bit         held_v;
	logic [7:0] prev_ch;
	logic [7:0] last_solid;
	bit         esc_next;
	bit         drop_next;
	bit         in_sq;
	bit         in_dq;
	bit         op_seen;
	bit         overflow;
	int         raw_len[2];
	int         kept_len[2];
	int         trim_len[2];

	res_t expected_items[$];
	int   fail_tally;
	int   line_tally;
	int   check_tally;

	function automatic bit is_blank(logic [7:0] c);
		return c == CH_SP || c == CH_TAB || c == CH_CR || c == CH_LF;
	endfunction

	function automatic int side_limit(bit s);
		int c;
		c = s ? right_cap : left_cap;
		return c > LINE_LIMIT ? LINE_LIMIT : c;
	endfunction

	task automatic clear_line();
		held_ch    = '0;
		held_v     = 0;
		prev_ch    = '0;
		last_solid = '0;
		esc_next   = 0;
		drop_next  = 0;
		in_sq      = 0;
		in_dq      = 0;
		op_seen    = 0;
		overflow   = 0;
		for (int i = 0; i < 2; i++) begin
			raw_len[i]  = 0;
			kept_len[i] = 0;
			trim_len[i] = 0;
		end
	endtask

	// need is the room to reserve on this side; zero when already reserved
	task automatic keep_char(logic [7:0] c, int need);
		res_t r;
		bit   s;
		s = op_seen;
		if (need != 0 && raw_len[s] + need >= side_limit(s)) begin
			overflow = 1;
			return;
		end
		raw_len[s]++;
		if (kept_len[s] == 0 && is_blank(c))
			return;
		r          = '0;
		r.out_byte = c;
		r.side     = s;
		r.position = POS_W'(kept_len[s]);
		expected_items.push_back(r);
		kept_len[s]++;
		if (!is_blank(c))
			trim_len[s] = kept_len[s];
	endtask

	function automatic int operator_width(logic [7:0] c, logic [7:0] nx, bit nv);
		case (kind)
			KIND_SEMI: return c == CH_SEMI ? 1 : 0;
			KIND_AND:  return (c == CH_AMP && nv && nx == CH_AMP) ? 2 : 0;
			KIND_OR:   return (c == CH_BAR && nv && nx == CH_BAR) ? 2 : 0;
			default: begin
				if (c != CH_AMP || (nv && nx == CH_AMP) || prev_ch == CH_AMP ||
						last_solid == CH_GT)
					return 0;
				return 1;
			end
		endcase
	endfunction

	task automatic consume_held(logic [7:0] nx, bit nv);
		logic [7:0] c;
		bit         nesc;
		bit         nskip;
		int         w;
		c     = held_ch;
		nesc  = 0;
		nskip = 0;
		if (drop_next) begin
			// second char of a two-char operator
		end else if (esc_next) begin
			if (!overflow)
				keep_char(c, 0);
		end else if (!in_sq && c == CH_BSL && nv) begin
			if (!overflow)
				keep_char(c, 2);
			nesc = 1;
		end else begin
			if (!in_dq && c == CH_SQ)
				in_sq = !in_sq;
			else if (!in_sq && c == CH_DQ)
				in_dq = !in_dq;
			w = (!op_seen && !in_sq && !in_dq) ? operator_width(c, nx, nv) : 0;
			if (w != 0) begin
				op_seen = 1;
				nskip   = (w == 2);
			end else if (!overflow) begin
				keep_char(c, 1);
			end
		end
		prev_ch = c;
		if (!is_blank(c))
			last_solid = c;
		held_ch   = nx;
		held_v    = nv;
		esc_next  = nesc;
		drop_next = nskip;
	endtask

	task automatic close_line();
		res_t       r;
		logic [1:0] st;
		if (held_v)
			consume_held('0, 0);
		if (overflow || left_cap == 0 || right_cap == 0)
			st = ST_ERR;
		else if (kind == KIND_BG && (in_sq || in_dq))
			st = ST_ERR;
		else if (!op_seen)
			st = ST_NONE;
		else if (trim_len[0] == 0)
			st = ST_ERR;
		else if (kind == KIND_BG)
			st = trim_len[1] == 0 ? ST_NONE : ST_SPLIT;
		else
			st = trim_len[1] == 0 ? ST_ERR : ST_SPLIT;
		r          = '0;
		r.is_final = 1;
		r.status   = st;
		if (st != ST_ERR) begin
			r.left_length  = POS_W'(trim_len[0]);
			r.right_length = op_seen ? POS_W'(trim_len[1]) : '0;
		end
		expected_items.push_back(r);
		line_tally++;
		clear_line();
	endtask

	task automatic take_char(cmd_t item);
		if (item.end_of_line) begin
			close_line();
		end else if (held_v) begin
			consume_held(item.in_byte, 1);
		end else begin
			held_ch   = item.in_byte;
			held_v    = 1;
			esc_next  = 0;
			drop_next = 0;
		end
	endtask

	task automatic apply_write(cfg_wr_t w);
		case (w.index)
			REG_KIND: kind = w.value[1:0];
			REG_LCAP: left_cap = int'(w.value);
			REG_RCAP: right_cap = int'(w.value);
			default: ;
		endcase
	endtask

	task automatic compare_result(res_t got);
		res_t want;
		if (expected_items.size() == 0) begin
			if (fail_tally < 10)
				$display("%0t: unexpected result: byte %h side %0d pos %0d fin %0d st %0d",
					$realtime, got.out_byte, got.side, got.position, got.is_final, got.status);
			fail_tally++;
			return;
		end
		want = expected_items.pop_front();
		check_tally++;
		if (got.out_byte !== want.out_byte || got.side !== want.side ||
				got.position !== want.position || got.is_final !== want.is_final ||
				got.status !== want.status || got.left_length !== want.left_length ||
				got.right_length !== want.right_length) begin
			if (fail_tally < 10) begin
				$display("%0t: mismatch", $realtime);
				$display("  expected byte %h side %0d pos %0d fin %0d st %0d len %0d/%0d",
					want.out_byte, want.side, want.position, want.is_final, want.status,
					want.left_length, want.right_length);
				$display("  actual   byte %h side %0d pos %0d fin %0d st %0d len %0d/%0d",
					got.out_byte, got.side, got.position, got.is_final, got.status,
					got.left_length, got.right_length);
			end
			fail_tally++;
		end
	endtask

	initial begin
		fail_tally  = 0;
		line_tally  = 0;
		check_tally = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind      = KIND_SEMI;
			left_cap  = int'(CAP_RESET);
			right_cap = int'(CAP_RESET);
			clear_line();
			expected_items.delete();
		end else begin
			if (res_valid && res_ready)
				compare_result(res_data);
			if (cfg_valid && cfg_ready)
				apply_write(cfg_data);
			if (cmd_valid && cmd_ready)
				take_char(cmd_data);
		end
		outstanding     <= expected_items.size();
		mismatches      <= fail_tally;
		lines_seen      <= line_tally;
		results_checked <= check_tally;
	end

endmodule

// File: test/tb_quote_aware_operator_splitter_unit.sv
module tb_quote_aware_operator_splitter_unit;
	timeunit 1ns;
	timeprecision 1ps;
	import qaos_pkg::*;

	// indexes past the register list
	localparam logic [7:0] REG_SPARE = 8'd3;
	localparam logic [7:0] REG_LAST  = 8'd255;

	logic clk = 0;
	logic arst_n;

	qaos_stream_if #(.T(cmd_t))    cmd_if();
	qaos_stream_if #(.T(res_t))    res_if();
	qaos_stream_if #(.T(cfg_wr_t)) cfg_if();

	int mismatches;
	int outstanding;
	int lines_seen;
	int results_checked;

	int         burst_left;
	int         chars_sent;
	int         stall_mode;
	int         stall_cycle;
	logic [7:0] line_buf[$];

	quote_aware_operator_splitter_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_if),
		.res    (res_if),
		.cfg    (cfg_if)
	);

	qaos_checker scoreboard (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd_valid       (cmd_if.valid),
		.cmd_ready       (cmd_if.ready),
		.cmd_data        (cmd_if.data),
		.res_valid       (res_if.valid),
		.res_ready       (res_if.ready),
		.res_data        (res_if.data),
		.cfg_valid       (cfg_if.valid),
		.cfg_ready       (cfg_if.ready),
		.cfg_data        (cfg_if.data),
		.mismatches      (mismatches),
		.outstanding     (outstanding),
		.lines_seen      (lines_seen),
		.results_checked (results_checked)
	);

	always #6 clk = ~clk;

	// receiver: switch between free flow, coin-flip and heavy back-pressure
	always @(posedge clk) begin
		if (stall_cycle == 0) begin
			stall_mode  = $urandom_range(0, 2);
			stall_cycle = $urandom_range(20, 150);
		end
		stall_cycle--;
		case (stall_mode)
			0:       res_if.ready <= 1'b1;
			1:       res_if.ready <= 1'($urandom_range(0, 1));
			default: res_if.ready <= ($urandom_range(0, 3) == 0);
		endcase
	end

	task automatic send_item(logic [7:0] ch, bit eol);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				cmd_if.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 12);
		end
		cmd_if.valid            <= 1'b1;
		cmd_if.data.in_byte     <= ch;
		cmd_if.data.end_of_line <= eol;
		do @(posedge clk); while (!cmd_if.ready);
		burst_left--;
	endtask

	task automatic send_line();
		foreach (line_buf[i]) begin
			send_item(line_buf[i], 0);
			chars_sent++;
		end
		// the char beside the end marker is ignored, so give it noise
		send_item(8'($urandom_range(0, 255)), 1);
	endtask

	task automatic send_text(string s);
		line_buf.delete();
		for (int i = 0; i < s.len(); i++)
			line_buf.push_back(s[i]);
		send_line();
	endtask

	task automatic drain();
		cmd_if.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [7:0] index, logic [CAP_W-1:0] value);
		cfg_if.valid      <= 1'b1;
		cfg_if.data.index <= index;
		cfg_if.data.value <= value;
		do @(posedge clk); while (!cfg_if.ready);
		cfg_if.valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [7:0] pick_blank();
		case ($urandom_range(0, 3))
			0:       return CH_SP;
			1:       return CH_TAB;
			2:       return CH_CR;
			default: return CH_LF;
		endcase
	endfunction

	function automatic logic [7:0] pick_special();
		case ($urandom_range(0, 7))
			0:       return CH_SEMI;
			1:       return CH_AMP;
			2:       return CH_BAR;
			3:       return CH_GT;
			4:       return CH_SQ;
			5:       return CH_DQ;
			6:       return CH_BSL;
			default: return CH_SP;
		endcase
	endfunction

	task automatic add_word();
		int         r;
		logic [7:0] qc;
		repeat ($urandom_range(1, 6)) begin
			r = $urandom_range(0, 19);
			if (r < 10) begin
				line_buf.push_back(8'h61 + 8'($urandom_range(0, 25)));
			end else if (r < 13) begin
				line_buf.push_back(pick_blank());
			end else if (r == 13) begin
				line_buf.push_back(CH_BSL);
				line_buf.push_back(pick_special());
			end else if (r == 14) begin
				qc = $urandom_range(0, 1) ? CH_SQ : CH_DQ;
				line_buf.push_back(qc);
				line_buf.push_back(8'h61 + 8'($urandom_range(0, 25)));
				line_buf.push_back(pick_special());
				line_buf.push_back(qc);
			end else if (r == 15) begin
				line_buf.push_back(CH_GT);
			end else if (r == 16) begin
				line_buf.push_back(CH_AMP);
			end else if (r == 17) begin
				line_buf.push_back(8'($urandom_range(0, 255)));
			end else begin
				line_buf.push_back(pick_special());
			end
		end
	endtask

	// mostly "word OP word" with random content; the rest is noise
	task automatic build_line(logic [1:0] k);
		line_buf.delete();
		if ($urandom_range(0, 9) < 7) begin
			repeat ($urandom_range(0, 2)) line_buf.push_back(pick_blank());
			add_word();
			if ($urandom_range(0, 4) != 0) begin
				repeat ($urandom_range(0, 2)) line_buf.push_back(CH_SP);
				case (k)
					KIND_SEMI: line_buf.push_back(CH_SEMI);
					KIND_AND: begin
						line_buf.push_back(CH_AMP);
						line_buf.push_back(CH_AMP);
					end
					KIND_OR: begin
						line_buf.push_back(CH_BAR);
						line_buf.push_back(CH_BAR);
					end
					default: line_buf.push_back(CH_AMP);
				endcase
				repeat ($urandom_range(0, 2)) line_buf.push_back(CH_SP);
			end
			if ($urandom_range(0, 6) != 0)
				add_word();
			repeat ($urandom_range(0, 2)) line_buf.push_back(pick_blank());
		end else begin
			repeat ($urandom_range(0, 12))
				line_buf.push_back($urandom_range(0, 1) ? pick_special()
					: 8'($urandom_range(0, 255)));
		end
	endtask

	task automatic random_lines(logic [1:0] k);
		int start;
		start = chars_sent;
		while (chars_sent - start < 45) begin
			build_line(k);
			send_line();
		end
	endtask

	task automatic run_phase(logic [1:0] k, logic [CAP_W-1:0] lcap, logic [CAP_W-1:0] rcap);
		drain();
		write_reg(REG_KIND, {11'($urandom), k});
		write_reg(REG_LCAP, lcap);
		write_reg(REG_RCAP, rcap);
		random_lines(k);
	endtask

	initial begin
		burst_left  = 0;
		chars_sent  = 0;
		arst_n      = 1'b0;
		cmd_if.valid <= 1'b0;
		cmd_if.data  <= '0;
		cfg_if.valid <= 1'b0;
		cfg_if.data  <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset defaults: split on ';'
		send_text("a;b");
		send_text("\\;'");
		send_text("");
		line_buf.delete();
		line_buf.push_back(8'h00);
		line_buf.push_back(8'hFF);
		send_line();
		send_text(";x");
		send_text("x\\");
		send_text("\"a;\"");
		random_lines(KIND_SEMI);

		run_phase(KIND_AND,  13'd4096, 13'd4096);
		run_phase(KIND_OR,   13'd8191, 13'd1);
		run_phase(KIND_BG,   13'd1,    13'd8191);
		run_phase(KIND_BG,   13'd12,   13'd9);
		run_phase(KIND_SEMI, 13'd0,    13'd20);
		drain();
		write_reg(REG_SPARE, 13'($urandom));
		write_reg(REG_LAST, 13'($urandom));
		run_phase(KIND_AND,  13'd7,    13'd4096);
		run_phase(KIND_OR,   13'd20,   13'd0);
		run_phase(KIND_BG,   13'd256,  13'd256);

		drain();
		repeat (8) @(posedge clk);
		$display("Streamed %0d chars in %0d lines and checked %0d results,", chars_sent,
			lines_seen, results_checked);
		$display("over all four split kinds and capacities from 0 to 8191.");
		if (mismatches == 0 && outstanding == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	initial begin
		#5ms;
		$display("Timeout with %0d results still expected", outstanding);
		$display("Some tests failed");
		$finish;
	end

endmodule
